@@ rtl/assert_macros.svh @@
// assertion macros used by the top-level rtl file
// no dependencies; assertions are compiled out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`define ASSERT_CLK_RST(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, prop, msg)
`define ASSERT_CLK_RST(lbl, clk, rst_n, prop, msg)
`endif

`endif

@@ rtl/bboe_pkg.sv @@
// package for the byte budget eviction block: field widths, codes, entry layout
// no dependencies
package bboe_pkg;

	localparam int KEY_W      = 64;
	localparam int SIZE_W     = 32;
	localparam int TIME_W     = 63;
	localparam int TOTAL_W    = 38;
	localparam int CFG_W      = 40;
	localparam int CFG_IDX_W  = 4;
	localparam int IN_DATA_W  = 160;
	localparam int OUT_DATA_W = 136;

	localparam int TABLE_DEPTH_DEF = 32;

	localparam logic [CFG_W-1:0] MAX_BYTES_RST    = 40'd268435456;
	localparam logic [CFG_W-1:0] TARGET_BYTES_RST = 40'd241591910;

	localparam logic [CFG_IDX_W-1:0] CFG_MAX_BYTES    = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TARGET_BYTES = 4'd1;

	localparam logic REQ_RECORD = 1'b0;
	localparam logic REQ_PUT    = 1'b1;

	localparam logic KIND_EVICT  = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	typedef enum logic [1:0] {
		STAT_NEW,
		STAT_REPLACED,
		STAT_FULL
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DUP_SCAN,
		ST_INSERT,
		ST_CAP_CHECK,
		ST_EVICT_CHECK,
		ST_OLD_SCAN,
		ST_EVICT,
		ST_STATUS
	} state_t;

	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [SIZE_W-1:0] size;
		logic [TIME_W-1:0] stamp;
	} entry_t;

endpackage

@@ rtl/byte_budget_oldest_first_eviction.sv @@
// top level of the byte budget cache bookkeeping block with oldest-first eviction
// depends on bboe_pkg, bboe_ram and assert_macros.svh
//
// One request at a time. Entries (key, size, write time) live in a single-port
// ram with registered read data; valid bits and the byte total are flip-flops.
// A record goes from acceptance through insert, cap check and status back to
// idle before the next s_tready. A put first sweeps every slot for a matching
// key, then inserts into the lowest free slot and checks the cap. If the total
// is above max_bytes, each eviction takes a check state, an oldest-entry sweep
// and an eviction state, and one more check ends the loop once the total is at
// or below target_bytes or the table is empty. Each sweep is bound by the
// single ram read port. One eviction report per evicted entry, then one status
// transaction with tlast set. Results wait in an output register while
// m_tready is low, which adds stall cycles to eviction and status.
`include "assert_macros.svh"

module byte_budget_oldest_first_eviction
	import bboe_pkg::*;
#(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // key_hash, entry_size, write_time, zero pad
	input  logic                  s_tuser,   // req_type
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // evicted_key, evicted_size, total_now, status
	output logic                  m_tuser,   // kind
	output logic                  m_tlast,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]      cfg_data
);

	localparam int IDX_W   = $clog2(TABLE_DEPTH);
	localparam int ENTRY_W = $bits(entry_t);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

	state_t state_q, state_d;

	logic [CFG_W-1:0]   max_q, target_q;
	logic [TOTAL_W-1:0] total_q;
	logic [TABLE_DEPTH-1:0] valid_q;
	status_t            status_q;
	logic               req_put_q;
	logic [KEY_W-1:0]   req_key_q;
	logic [SIZE_W-1:0]  req_size_q;
	logic [TIME_W-1:0]  req_time_q;

	logic               scan_on_q;
	logic [IDX_W-1:0]   scan_idx_q;
	logic               cmp_vld_s1;
	logic [IDX_W-1:0]   cmp_idx_s1;
	logic               dup_found_q;

	logic               best_found_q;
	logic [IDX_W-1:0]   best_idx_q;
	logic [KEY_W-1:0]   best_key_q;
	logic [SIZE_W-1:0]  best_size_q;
	logic [TIME_W-1:0]  best_time_q;

	logic               out_valid_q;
	logic               out_kind_q;
	logic               out_last_q;
	logic [KEY_W-1:0]   out_key_q;
	logic [SIZE_W-1:0]  out_size_q;
	logic [TOTAL_W-1:0] out_total_q;
	status_t            out_status_q;

	// ram interface
	logic               ram_we;
	logic [IDX_W-1:0]   ram_addr;
	entry_t             ram_wdata, rd_entry;
	logic [ENTRY_W-1:0] ram_rdata;

	// fsm outputs and datapath helpers
	logic               scan_start, scan_done, out_free;
	logic               load_evict, load_status;
	logic               free_found;
	logic [IDX_W-1:0]   free_idx;
	logic               over_cap, over_target, go_evict;
	logic               dup_hit, old_hit;
	logic [TOTAL_W:0]   sum_ext;
	logic [TOTAL_W-1:0] ins_total, dup_total, ev_total;

	bboe_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TABLE_DEPTH)
	) u_slot_ram (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	assign rd_entry = entry_t'(ram_rdata);

	// lowest free slot
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_found = 1'b1;
				free_idx   = IDX_W'(i);
			end
		end
	end

	assign sum_ext   = {1'b0, total_q} + (TOTAL_W + 1)'(req_size_q);
	assign ins_total = sum_ext[TOTAL_W] ? {TOTAL_W{1'b1}} : sum_ext[TOTAL_W-1:0];
	assign dup_total = (total_q > TOTAL_W'(rd_entry.size)) ?
		(total_q - TOTAL_W'(rd_entry.size)) : '0;
	assign ev_total  = (total_q > TOTAL_W'(best_size_q)) ?
		(total_q - TOTAL_W'(best_size_q)) : '0;

	assign over_cap    = CFG_W'(total_q) > max_q;
	assign over_target = CFG_W'(total_q) > target_q;
	assign go_evict    = over_target && (|valid_q);

	assign scan_done = cmp_vld_s1 && (cmp_idx_s1 == LAST_IDX);
	assign out_free  = !out_valid_q || m_tready;

	assign dup_hit = (state_q == ST_DUP_SCAN) && cmp_vld_s1 && valid_q[cmp_idx_s1] &&
		(rd_entry.key == req_key_q) && !dup_found_q;
	assign old_hit = (state_q == ST_OLD_SCAN) && cmp_vld_s1 && valid_q[cmp_idx_s1] &&
		(!best_found_q || (rd_entry.stamp < best_time_q));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = (s_tuser == REQ_PUT) ? ST_DUP_SCAN : ST_INSERT;
				end
			end
			ST_DUP_SCAN: begin
				if (scan_done) begin
					state_d = ST_INSERT;
				end
			end
			ST_INSERT: begin
				state_d = ST_CAP_CHECK;
			end
			ST_CAP_CHECK: begin
				state_d = (req_put_q && over_cap) ? ST_EVICT_CHECK : ST_STATUS;
			end
			ST_EVICT_CHECK: begin
				state_d = go_evict ? ST_OLD_SCAN : ST_STATUS;
			end
			ST_OLD_SCAN: begin
				if (scan_done) begin
					state_d = ST_EVICT;
				end
			end
			ST_EVICT: begin
				if (out_free) begin
					state_d = ST_EVICT_CHECK;
				end
			end
			ST_STATUS: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// fsm outputs
	always_comb begin
		s_tready    = (state_q == ST_IDLE);
		ram_we      = (state_q == ST_INSERT) && free_found;
		ram_addr    = ram_we ? free_idx : scan_idx_q;
		scan_start  = ((state_q == ST_IDLE) && s_tvalid && (s_tuser == REQ_PUT)) ||
			((state_q == ST_EVICT_CHECK) && go_evict);
		load_evict  = (state_q == ST_EVICT) && out_free;
		load_status = (state_q == ST_STATUS) && out_free;
	end

	assign ram_wdata = {req_key_q, req_size_q, req_time_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q    <= MAX_BYTES_RST;
			target_q <= TARGET_BYTES_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_MAX_BYTES:    max_q    <= cfg_data;
				CFG_TARGET_BYTES: target_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			req_put_q  <= s_tuser;
			req_key_q  <= s_tdata[KEY_W-1:0];
			req_size_q <= s_tdata[KEY_W +: SIZE_W];
			req_time_q <= s_tdata[KEY_W + SIZE_W +: TIME_W];
		end
	end

	// slot sweep: address issue, compare in the cycle after
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_on_q  <= 1'b0;
			scan_idx_q <= '0;
			cmp_vld_s1 <= 1'b0;
			cmp_idx_s1 <= '0;
		end else begin
			cmp_vld_s1 <= scan_on_q;
			cmp_idx_s1 <= scan_idx_q;
			if (scan_start) begin
				scan_on_q  <= 1'b1;
				scan_idx_q <= '0;
			end else if (scan_on_q) begin
				if (scan_idx_q == LAST_IDX) begin
					scan_on_q <= 1'b0;
				end else begin
					scan_idx_q <= scan_idx_q + 1'b1;
				end
			end
		end
	end

	// table bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= '0;
			total_q      <= '0;
			status_q     <= STAT_NEW;
			dup_found_q  <= 1'b0;
			best_found_q <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				status_q    <= STAT_NEW;
				dup_found_q <= 1'b0;
			end
			if (dup_hit) begin
				valid_q[cmp_idx_s1] <= 1'b0;
				total_q             <= dup_total;
				status_q            <= STAT_REPLACED;
				dup_found_q         <= 1'b1;
			end
			if (state_q == ST_INSERT) begin
				if (free_found) begin
					valid_q[free_idx] <= 1'b1;
					total_q           <= ins_total;
				end else begin
					status_q <= STAT_FULL;
				end
			end
			if (scan_start) begin
				best_found_q <= 1'b0;
			end else if (old_hit) begin
				best_found_q <= 1'b1;
			end
			if (load_evict) begin
				valid_q[best_idx_q] <= 1'b0;
				total_q             <= ev_total;
			end
		end
	end

	// oldest candidate, strict compare keeps the lowest slot on equal times
	always_ff @(posedge clk) begin
		if (old_hit) begin
			best_idx_q  <= cmp_idx_s1;
			best_key_q  <= rd_entry.key;
			best_size_q <= rd_entry.size;
			best_time_q <= rd_entry.stamp;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_evict || load_status) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_evict) begin
			out_kind_q   <= KIND_EVICT;
			out_last_q   <= 1'b0;
			out_key_q    <= best_key_q;
			out_size_q   <= best_size_q;
			out_total_q  <= ev_total;
			out_status_q <= STAT_NEW;
		end else if (load_status) begin
			out_kind_q   <= KIND_STATUS;
			out_last_q   <= 1'b1;
			out_key_q    <= '0;
			out_size_q   <= '0;
			out_total_q  <= total_q;
			out_status_q <= status_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {out_status_q, out_total_q, out_size_q, out_key_q};

	`ASSERT_CLK_RST(a_evict_slot_valid, clk, arst_n, (state_q == ST_EVICT) |-> valid_q[best_idx_q], "evicting a slot that is not valid")
	`ASSERT_CLK_RST(a_status_is_last, clk, arst_n, m_tvalid |-> (m_tuser == m_tlast), "status transaction and tlast disagree")
	`ASSERT_CLK_RST(a_one_req_at_a_time, clk, arst_n, (s_tvalid && s_tready) |=> !s_tready, "input taken while a request is in progress")

endmodule

@@ rtl/bboe_ram.sv @@
// generic single-port ram with registered read data
// no dependencies
module bboe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

@@ tb/byte_budget_oldest_first_eviction_tb.sv @@
// testbench for byte_budget_oldest_first_eviction: random and directed requests checked
// against a cycle-free model of the entry table, byte total and eviction order
// depends on bboe_pkg and the block's rtl
module byte_budget_oldest_first_eviction_tb;
	import bboe_pkg::*;

	localparam int DEPTH = TABLE_DEPTH_DEF;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_TARGET_BYTES + 1'b1;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = '1;
	localparam logic [CFG_W-1:0] CFG_ALL_ONES = '1;

	typedef struct {
		logic               kind;
		logic [KEY_W-1:0]   key;
		logic [SIZE_W-1:0]  size;
		logic [TOTAL_W-1:0] total;
		status_t            status;
		logic               last;
	} cache_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_DATA_W-1:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic m_tuser;
	logic m_tlast;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;

	// shadow of the entry table and registers
	logic [KEY_W-1:0]   slot_key_q [DEPTH];
	logic [SIZE_W-1:0]  slot_size_q [DEPTH];
	logic [TIME_W-1:0]  slot_stamp_q [DEPTH];
	logic               slot_used_q [DEPTH];
	logic [TOTAL_W-1:0] byte_sum;
	logic [CFG_W-1:0]   cap_bytes = MAX_BYTES_RST;
	logic [CFG_W-1:0]   floor_bytes = TARGET_BYTES_RST;

	cache_result_t expected_results[$];
	int mismatch_count = 0;
	int burst_left = 0;
	int ready_run = 0;
	int ready_mode = 0;
	logic [KEY_W-1:0] key_pool [12];
	logic [TIME_W-1:0] stamp_clock = '0;

	byte_budget_oldest_first_eviction DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	initial begin
		#30_000_000;
		$display("byte_budget_oldest_first_eviction: mismatch");
		$finish;
	end

	// receiver: stretches of always ready, random stalls and sparse ready
	always @(negedge clk) begin
		if (ready_run == 0) begin
			ready_mode = $urandom_range(0, 2);
			ready_run = $urandom_range(8, 64);
		end
		ready_run--;
		case (ready_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= 1'($urandom_range(0, 1));
			default: m_tready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	task automatic flag_error(input string what, input logic [KEY_W-1:0] want,
			input logic [KEY_W-1:0] got);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%0t: %s expected %h got %h", $realtime, what, want, got);
	endtask

	always @(posedge clk) begin
		cache_result_t exp_r;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_results.size() == 0) begin
				flag_error("result with nothing pending", '0, m_tdata[KEY_W-1:0]);
			end else begin
				exp_r = expected_results.pop_front();
				if (m_tuser !== exp_r.kind)
					flag_error("kind", KEY_W'(exp_r.kind), KEY_W'(m_tuser));
				if (m_tdata[63:0] !== exp_r.key)
					flag_error("evicted_key", exp_r.key, m_tdata[63:0]);
				if (m_tdata[95:64] !== exp_r.size)
					flag_error("evicted_size", KEY_W'(exp_r.size), KEY_W'(m_tdata[95:64]));
				if (m_tdata[133:96] !== exp_r.total)
					flag_error("total_now", KEY_W'(exp_r.total), KEY_W'(m_tdata[133:96]));
				if (m_tdata[135:134] !== exp_r.status)
					flag_error("status", KEY_W'(exp_r.status), KEY_W'(m_tdata[135:134]));
				if (m_tlast !== exp_r.last)
					flag_error("last", KEY_W'(exp_r.last), KEY_W'(m_tlast));
			end
		end
	end

	function automatic void push_result(input logic kind, input logic [KEY_W-1:0] key,
			input logic [SIZE_W-1:0] size, input status_t st, input logic last);
		cache_result_t r;
		r.kind = kind;
		r.key = key;
		r.size = size;
		r.total = byte_sum;
		r.status = st;
		r.last = last;
		expected_results.insert(expected_results.size(), r);
	endfunction

	// replace, insert into lowest free slot, then oldest-first eviction for puts
	function automatic void apply_request(input logic req, input logic [KEY_W-1:0] key,
			input logic [SIZE_W-1:0] size, input logic [TIME_W-1:0] stamp);
		status_t st;
		int free_idx;
		int oldest;
		int evicted;
		int i;
		logic [TOTAL_W:0] sum_ext;
		st = STAT_NEW;
		free_idx = -1;
		evicted = 0;
		if (req == REQ_PUT) begin
			for (i = 0; i < DEPTH; i++) begin
				if (slot_used_q[i] && slot_key_q[i] == key) begin
					byte_sum = (byte_sum > slot_size_q[i]) ? byte_sum - slot_size_q[i] : '0;
					slot_used_q[i] = 1'b0;
					st = STAT_REPLACED;
					break;
				end
			end
		end
		for (i = 0; i < DEPTH; i++) begin
			if (!slot_used_q[i]) begin
				free_idx = i;
				break;
			end
		end
		if (free_idx < 0) begin
			st = STAT_FULL;
		end else begin
			slot_key_q[free_idx] = key;
			slot_size_q[free_idx] = size;
			slot_stamp_q[free_idx] = stamp;
			slot_used_q[free_idx] = 1'b1;
			sum_ext = {1'b0, byte_sum} + (TOTAL_W + 1)'(size);
			byte_sum = sum_ext[TOTAL_W] ? '1 : sum_ext[TOTAL_W-1:0];
		end
		if (req == REQ_PUT && byte_sum > cap_bytes) begin
			while (byte_sum > floor_bytes && evicted < DEPTH) begin
				oldest = -1;
				for (i = 0; i < DEPTH; i++)
					if (slot_used_q[i] && (oldest < 0 || slot_stamp_q[i] < slot_stamp_q[oldest]))
						oldest = i;
				if (oldest < 0)
					break;
				slot_used_q[oldest] = 1'b0;
				byte_sum = (byte_sum > slot_size_q[oldest]) ? byte_sum - slot_size_q[oldest] : '0;
				push_result(KIND_EVICT, slot_key_q[oldest], slot_size_q[oldest], STAT_NEW, 1'b0);
				evicted++;
			end
		end
		push_result(KIND_STATUS, '0, '0, st, 1'b1);
	endfunction

	function automatic int used_slots();
		int n;
		n = 0;
		for (int i = 0; i < DEPTH; i++)
			n += slot_used_q[i];
		return n;
	endfunction

	// one request transaction; valid stays high across a burst
	task automatic send_request(input logic req, input logic [KEY_W-1:0] key,
			input logic [SIZE_W-1:0] size, input logic [TIME_W-1:0] stamp);
		@(negedge clk);
		if (burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
			burst_left = $urandom_range(1, 8);
		end
		s_tvalid <= 1'b1;
		s_tuser <= req;
		s_tdata <= {1'b0, stamp, size, key};
		do @(posedge clk); while (!s_tready);
		apply_request(req, key, size, stamp);
		burst_left--;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (expected_results.size() != 0) @(negedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_MAX_BYTES)
			cap_bytes = val;
		else if (idx == CFG_TARGET_BYTES)
			floor_bytes = val;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// field extremes, duplicate records, replace, self-eviction and time ties
	task automatic test_directed_edges();
		send_request(REQ_RECORD, '0, '0, '0);
		send_request(REQ_RECORD, '1, '1, '1);
		send_request(REQ_RECORD, '1, 32'd1, 63'd5);
		send_request(REQ_PUT, '1, 32'd100, 63'd10);
		send_request(REQ_PUT, 64'h0123_4567_89ab_cdef, '1, 63'd3);
		send_request(REQ_RECORD, 64'h5555_5555_5555_5555, 32'd10, 63'd50);
		send_request(REQ_RECORD, 64'haaaa_aaaa_aaaa_aaaa, 32'd10, 63'd50);
		send_request(REQ_PUT, 64'h8000_0000_0000_0001, '1, 63'd60);
		send_request(REQ_PUT, '0, '0, '1);
		send_request(REQ_PUT, 64'hffff_0000_ffff_0000, 32'h8000_0000, '0);
	endtask

	// fill with records, then reject, replace while full and evict down to a zero byte total
	task automatic test_table_full();
		logic [TIME_W-1:0] stamp;
		write_register(CFG_MAX_BYTES, CFG_ALL_ONES);
		write_register(CFG_TARGET_BYTES, CFG_ALL_ONES);
		stamp = 63'd100;
		while (used_slots() < DEPTH) begin
			send_request(REQ_RECORD, {32'hc0de_0000, 32'(stamp)}, $urandom_range(0, 4096), stamp);
			stamp++;
		end
		send_request(REQ_RECORD, 64'h1111_2222_3333_4444, 32'd7, stamp);
		send_request(REQ_PUT, 64'h1111_2222_3333_4444, 32'd7, stamp);
		send_request(REQ_PUT, {32'hc0de_0000, 32'd105}, 32'd9, stamp + 1'b1);
		write_register(CFG_MAX_BYTES, '0);
		write_register(CFG_TARGET_BYTES, '0);
		send_request(REQ_RECORD, 64'h0f0f_0f0f_0f0f_0f0f, 32'd1, stamp + 2'd2);
		send_request(REQ_PUT, 64'h7777_7777_7777_7777, 32'd5, stamp + 2'd3);
		// cap exceeded but already below target: no eviction
		write_register(CFG_TARGET_BYTES, CFG_ALL_ONES);
		send_request(REQ_PUT, 64'h6666_6666_6666_6666, 32'd5, stamp + 3'd4);
	endtask

	task automatic test_spare_registers();
		write_register(CFG_SPARE_LO, {$urandom, 8'(CFG_ALL_ONES)});
		write_register(CFG_SPARE_HI, {8'($urandom), $urandom});
		send_request(REQ_PUT, 64'h2222_2222_2222_2222, 32'd3, 63'd1);
	endtask

	task automatic send_random(input logic [SIZE_W-1:0] size_top, input bit wide_stamp);
		logic req;
		logic [KEY_W-1:0] key;
		logic [TIME_W-1:0] stamp;
		req = ($urandom_range(0, 3) != 0) ? REQ_PUT : REQ_RECORD;
		if ($urandom_range(0, 3) == 0)
			key = {$urandom, $urandom};
		else
			key = key_pool[$urandom_range(0, 11)];
		if (wide_stamp) begin
			stamp = TIME_W'({$urandom, $urandom});
		end else begin
			case ($urandom_range(0, 5))
				0: stamp = stamp_clock;
				1: stamp = stamp_clock - TIME_W'($urandom_range(0, 20));
				default: begin
					stamp_clock += TIME_W'($urandom_range(1, 5));
					stamp = stamp_clock;
				end
			endcase
		end
		send_request(req, key, $urandom_range(0, size_top), stamp);
	endtask

	task automatic random_phase(input logic [CFG_W-1:0] cap, input logic [CFG_W-1:0] floor_val,
			input logic [SIZE_W-1:0] size_top, input bit wide_stamp, input int n_items);
		write_register(CFG_MAX_BYTES, cap);
		write_register(CFG_TARGET_BYTES, floor_val);
		for (int k = 0; k < n_items; k++) begin
			if ($urandom_range(0, 19) == 0)
				wait_drained();
			send_random(size_top, wide_stamp);
		end
	endtask

	task automatic test_random_traffic();
		logic [CFG_W-1:0] cap;
		foreach (key_pool[k])
			key_pool[k] = {$urandom, $urandom};
		stamp_clock = 63'd1000;
		random_phase(40'd1000, 40'd900, 32'd300, 1'b0, 25);
		cap = {4'd0, 4'($urandom_range(0, 15)), $urandom};
		random_phase(cap, cap - cap / 10, '1, 1'b1, 25);
		random_phase(40'd5000, '0, 32'd2000, 1'b0, 25);
	endtask

	initial begin
		byte_sum = '0;
		foreach (slot_used_q[k])
			slot_used_q[k] = 1'b0;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		test_directed_edges();
		test_table_full();
		test_spare_registers();
		test_random_traffic();
		wait_drained();
		repeat (100) @(negedge clk);
		if (mismatch_count == 0)
			$display("byte_budget_oldest_first_eviction: match");
		else
			$display("byte_budget_oldest_first_eviction: mismatch");
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/bboe_pkg.sv
rtl/bboe_ram.sv
rtl/byte_budget_oldest_first_eviction.sv
tb/byte_budget_oldest_first_eviction_tb.sv
